// File: rtl/tmi_pkg.sv
`default_nettype none
package tmi_pkg;
  localparam int AzimuthCells = 64;
  localparam int RadialCells  = 32;
  localparam int PolarCells   = 16;
  localparam int AzW = $clog2(AzimuthCells);
  localparam int RaW = $clog2(RadialCells);
  localparam int PoW = $clog2(PolarCells);
  localparam int MeshDepth = AzimuthCells * RadialCells * PolarCells;
  localparam int MeshAw = $clog2(MeshDepth);
  localparam logic signed [33:0] TwoPiQ16 = 34'sd411775;
  localparam logic signed [49:0] FracLimit = 50'sd536870912;

  typedef enum logic [2:0] {
    OP_WR_MESH = 3'd0,
    OP_WR_AZ   = 3'd1,
    OP_WR_RA   = 3'd2,
    OP_WR_PO   = 3'd3,
    OP_QUERY   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_AZ_USED = 2'd0,
    REG_PO_USED = 2'd1,
    REG_RA_USED = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CEN, S_FRAC, S_DIV, S_MREQ, S_MWAIT, S_MUL, S_ADD, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [49:0] num;
    logic signed [33:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [49:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/tmi_if.sv
`default_nettype none
interface tmi_in_if;
  logic valid;
  logic ready;
  logic [2:0] op;
  logic [5:0] azimuth_index;
  logic [4:0] radial_index;
  logic [3:0] polar_index;
  logic signed [31:0] write_value;
  logic signed [31:0] azimuth_pos;
  logic signed [31:0] radial_pos;
  logic signed [31:0] polar_pos;
  modport source (output valid, op, azimuth_index, radial_index, polar_index,
                  write_value, azimuth_pos, radial_pos, polar_pos, input ready);
  modport sink (input valid, op, azimuth_index, radial_index, polar_index,
                write_value, azimuth_pos, radial_pos, polar_pos, output ready);
endinterface

interface tmi_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] interp_value;
  logic index_error;
  modport source (output valid, interp_value, index_error, input ready);
  modport sink (input valid, interp_value, index_error, output ready);
endinterface
`default_nettype wire

// File: rtl/tmi_div.sv
`default_nettype none
// restoring divider, one quotient bit a cycle, truncates toward zero
module tmi_div (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tmi_pkg::div_req_t req,
  output tmi_pkg::div_rsp_t rsp
);
  import tmi_pkg::*;

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [49:0] q_r, q_nxt;
  logic [50:0] rem_r, rem_nxt;
  logic [33:0] d_r, d_nxt;
  logic        neg_r, neg_nxt;
  logic [50:0] trial;
  logic [49:0] num_abs;

  assign num_abs = req.num[49] ? 50'(-req.num) : 50'(req.num);
  assign trial = {rem_r[49:0], q_r[49]} - {17'd0, d_r};

  // shift-subtract step
  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    if (req.start) begin
      busy_nxt = 1'b1; cnt_nxt = 6'd0; q_nxt = num_abs; rem_nxt = '0;
      d_nxt = req.den[33] ? 34'(-req.den) : 34'(req.den);
      neg_nxt = req.num[49] ^ req.den[33];
    end else if (busy_r) begin
      if (!trial[50]) begin
        rem_nxt = trial; q_nxt = {q_r[48:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[49:0], q_r[49]}; q_nxt = {q_r[48:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd49) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? 50'(-q_r) : 50'(q_r);

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r)) else $error("done while busy");
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start) |=> (cnt_r == $past(cnt_r) + 6'd1) || !busy_r)
    else $error("counter slip");
endmodule
`default_nettype wire

// File: rtl/trilinear_mesh_interpolator_top.sv
`default_nettype none
// Trilinear mesh interpolator, signed Q16.16. Load words (ops 0..3) fill the
// mesh and the three center tables. In a query word up to three fractions
// share one serial divider, and up to eight mesh reads and seven blends go
// one at a time through a single mesh read port and one shared multiplier.
// The block takes one word at a time; in_ready is low while a word is at
// work or a result waits. Reading an entry that was never written gives an
// undefined value.
module trilinear_mesh_interpolator_top (
  input  wire logic clk,
  input  wire logic rst_n,
  tmi_in_if.sink    in_ch,
  tmi_out_if.source out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import tmi_pkg::*;

  // config registers
  logic [6:0] az_used_r;
  logic [4:0] po_used_r;
  logic [5:0] ra_used_r;
  reg_idx_t   cfg_idx;
  assign cfg_idx = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_used_r <= 7'd64; po_used_r <= 5'd16; ra_used_r <= 6'd32;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
      unique case (cfg_idx)
        REG_AZ_USED: az_used_r <= cfg_pwdata[6:0];
        REG_PO_USED: po_used_r <= cfg_pwdata[4:0];
        REG_RA_USED: ra_used_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'd0) begin
      unique case (cfg_idx)
        REG_AZ_USED: cfg_prdata = {25'd0, az_used_r};
        REG_PO_USED: cfg_prdata = {27'd0, po_used_r};
        REG_RA_USED: cfg_prdata = {26'd0, ra_used_r};
        default: cfg_prdata = '0;
      endcase
    end
  end

  // clamped counts
  logic [6:0] nx; logic [5:0] ny; logic [4:0] nz;
  assign nx = (az_used_r < 7'd2) ? 7'd2 : (az_used_r > 7'd64) ? 7'd64 : az_used_r;
  assign ny = (ra_used_r < 6'd2) ? 6'd2 : (ra_used_r > 6'd32) ? 6'd32 : ra_used_r;
  assign nz = (po_used_r < 5'd1) ? 5'd1 : (po_used_r > 5'd16) ? 5'd16 : po_used_r;

  // memories
  logic signed [31:0] mesh_mem [MeshDepth];
  logic signed [31:0] az_mem [AzimuthCells];
  logic signed [31:0] ra_mem [RadialCells];
  logic signed [31:0] po_mem [PolarCells];

  state_t state_r, state_nxt;
  logic [2:0] op_r;
  logic [AzW-1:0] i_r, i1_r;
  logic [RaW-1:0] j_r;
  logic [PoW-1:0] k_r;
  logic signed [31:0] wv_r, phi_r, rp_r, th_r;
  logic planar_r, err_r;
  logic [3:0] step_r, step_nxt;         // fetch or blend counter
  logic [1:0] fsel_r, fsel_nxt;         // fraction index
  logic signed [33:0] x0_r, x1_r, y0_r, y1_r, z0_r, z1_r, phi_adj_r;
  logic signed [31:0] az0_r;            // copy of azimuth center zero
  logic signed [47:0] f_r [3];
  logic signed [31:0] v_r [8];
  logic signed [31:0] rd_r;
  logic signed [31:0] tab_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] res_r;
  logic out_valid_r;
  logic out_err_r;

  // mesh read address for corner step
  logic [AzW-1:0] ai; logic [RaW-1:0] aj; logic [PoW-1:0] ak;
  logic [MeshAw-1:0] maddr;
  assign ai = step_r[0] ? i1_r : i_r;
  assign aj = step_r[1] ? RaW'(j_r + 1'b1) : j_r;
  assign ak = step_r[2] ? PoW'(k_r + 1'b1) : k_r;
  assign maddr = {ak, aj, ai};

  logic in_fire;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;

  // table and mesh writes, registered mesh read
  always_ff @(posedge clk) begin
    if (state_r == S_CEN && op_r == OP_WR_MESH)
      mesh_mem[{k_r, j_r, i_r}] <= wv_r;
    if (state_r == S_CEN && op_r == OP_WR_AZ) az_mem[i_r] <= wv_r;
    if (state_r == S_CEN && op_r == OP_WR_RA) ra_mem[j_r] <= wv_r;
    if (state_r == S_CEN && op_r == OP_WR_PO) po_mem[k_r] <= wv_r;
    rd_r <= mesh_mem[maddr];
  end

  // divider
  div_req_t dreq; div_rsp_t drsp;
  tmi_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  logic signed [33:0] fpos, flo, fhi;
  always_comb begin
    unique case (fsel_r)
      2'd0: begin fpos = phi_adj_r; flo = x0_r; fhi = x1_r; end
      2'd1: begin fpos = 34'(rp_r); flo = y0_r; fhi = y1_r; end
      default: begin fpos = 34'(th_r); flo = z0_r; fhi = z1_r; end
    endcase
  end
  logic signed [33:0] fden;
  assign fden = fhi - flo;
  assign dreq.start = (state_r == S_FRAC) && (fden != 34'sd0);
  assign dreq.num = 50'(fpos - flo) <<< 16;
  assign dreq.den = fden;

  // blend operands: steps 0..3 on corners, 4..5 radius, 6 polar
  logic signed [31:0] ba, bb; logic signed [47:0] bf;
  always_comb begin
    case (step_r)
      4'd0: begin ba = v_r[0]; bb = v_r[1]; bf = f_r[0]; end
      4'd1: begin ba = v_r[2]; bb = v_r[3]; bf = f_r[0]; end
      4'd2: begin ba = v_r[4]; bb = v_r[5]; bf = f_r[0]; end
      4'd3: begin ba = v_r[6]; bb = v_r[7]; bf = f_r[0]; end
      4'd4: begin ba = v_r[0]; bb = v_r[1]; bf = f_r[1]; end
      4'd5: begin ba = v_r[2]; bb = v_r[3]; bf = f_r[1]; end
      default: begin ba = v_r[0]; bb = v_r[2]; bf = f_r[2]; end
    endcase
  end
  logic signed [32:0] bdiff;
  logic signed [63:0] bsum;
  logic signed [31:0] bres;
  assign bdiff = 33'(ba) - 33'(bb);
  assign bsum = 64'(ba) + ((prod_r + 64'sd32768) >>> 16);
  assign bres = (bsum > 64'sd2147483647) ? 32'sh7fffffff :
                (bsum < -64'sd2147483648) ? 32'sh80000000 : 32'(bsum);

  logic [3:0] last_blend;
  assign last_blend = planar_r ? 4'd4 : 4'd6;

  // sequencer
  always_comb begin
    state_nxt = state_r; step_nxt = step_r; fsel_nxt = fsel_r;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        state_nxt = S_CEN; step_nxt = '0; fsel_nxt = '0;
      end
      S_CEN: state_nxt = (op_r == OP_QUERY) ? (err_r ? S_OUT : S_FRAC) : S_IDLE;
      S_FRAC: state_nxt = S_DIV;
      S_DIV: if (fden == 34'sd0 || drsp.done) begin
        if (fsel_r == (planar_r ? 2'd1 : 2'd2)) begin
          state_nxt = S_MREQ; step_nxt = '0;
        end else begin
          fsel_nxt = fsel_r + 2'd1; state_nxt = S_FRAC;
        end
      end
      S_MREQ: state_nxt = S_MWAIT;
      S_MWAIT: if (step_r == (planar_r ? 4'd3 : 4'd7)) begin
        state_nxt = S_MUL; step_nxt = '0;
      end else begin
        step_nxt = step_r + 4'd1; state_nxt = S_MREQ;
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: if (step_r == last_blend) state_nxt = S_OUT;
        else begin
          step_nxt = (planar_r && step_r == 4'd1) ? 4'd4 : step_r + 4'd1;
          state_nxt = S_MUL;
        end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // clamp a divider quotient, or zero when the denominator is zero
  logic signed [49:0] fq;
  assign fq = (fden == 34'sd0) ? 50'sd0 :
              (drsp.quo > FracLimit) ? FracLimit :
              (drsp.quo < -FracLimit) ? -FracLimit : drsp.quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0; step_r <= '0; fsel_r <= '0;
    end else begin
      state_r <= state_nxt; step_r <= step_nxt; fsel_r <= fsel_nxt;
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= in_ch.op; i_r <= in_ch.azimuth_index; j_r <= in_ch.radial_index;
      k_r <= in_ch.polar_index; wv_r <= in_ch.write_value;
      phi_r <= in_ch.azimuth_pos; rp_r <= in_ch.radial_pos; th_r <= in_ch.polar_pos;
      err_r <= (7'(in_ch.azimuth_index) >= nx) ||
               (6'(in_ch.radial_index) + 6'd1 >= ny) ||
               (5'(in_ch.polar_index) >= nz);
      planar_r <= (5'(in_ch.polar_index) == nz - 5'd1);
      i1_r <= (7'(in_ch.azimuth_index) == nx - 7'd1) ? '0 : AzW'(in_ch.azimuth_index + 1'b1);
    end
    if (state_r == S_CEN && op_r == OP_WR_AZ && i_r == '0) az0_r <= wv_r;
    if (state_r == S_CEN) begin
      x0_r <= 34'(az_mem[i_r]);
      x1_r <= (i1_r == '0) ? 34'(az0_r) + TwoPiQ16 : 34'(az_mem[i1_r]);
      y0_r <= 34'(ra_mem[j_r]); y1_r <= 34'(ra_mem[RaW'(j_r + 1'b1)]);
      z0_r <= 34'(po_mem[k_r]); z1_r <= 34'(po_mem[PoW'(k_r + 1'b1)]);
      phi_adj_r <= (phi_r < az0_r) ? 34'(phi_r) + TwoPiQ16 : 34'(phi_r);
    end
    if (state_r == S_DIV && (fden == 34'sd0 || drsp.done)) f_r[fsel_r] <= fq[47:0];
    if (state_r == S_MWAIT) v_r[step_r[2:0]] <= rd_r;
    if (state_r == S_MUL) prod_r <= 64'(-bdiff) * 64'(bf);
    if (state_r == S_ADD) begin
      case (step_r)
        4'd0: v_r[0] <= bres; 4'd1: v_r[1] <= bres;
        4'd2: v_r[2] <= bres; 4'd3: v_r[3] <= bres;
        4'd4: v_r[0] <= bres; 4'd5: v_r[2] <= bres;
        default: v_r[0] <= bres;
      endcase
      res_r <= bres;
    end
    if (state_r == S_OUT) out_err_r <= err_r;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.interp_value = out_err_r ? 32'sd0 : res_r;
  assign out_ch.index_error = out_err_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == S_IDLE) else $error("accept while busy");
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT) else $error("stray result");
  a_div_only_frac: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> state_r == S_DIV) else $error("divider out of step");
endmodule
`default_nettype wire
